// ===== hw/rtl/lfr_pkg.sv =====
// Shared types and constants for the link frame receiver.
// No dependencies; imported by every other file of the block.
`default_nettype none

package lfr_pkg;

    // Line codes
    localparam logic [7:0] FLAG_BYTE = 8'h5C;
    localparam logic [7:0] ESC_BYTE  = 8'h5D;
    localparam logic [7:0] ESC_MASK  = 8'h20;
    localparam logic [7:0] ESC_FLAG  = FLAG_BYTE ^ ESC_MASK;
    localparam logic [7:0] ESC_ESC   = ESC_BYTE ^ ESC_MASK;

    // Control field codes
    localparam logic [7:0] CTRL_SET = 8'h03;
    localparam logic [7:0] CTRL_I0  = 8'h00;
    localparam logic [7:0] CTRL_I1  = 8'h02;

    localparam logic [7:0] OWN_ADDR_RESET = 8'h01;

    // Result kind codes
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Frame type codes
    localparam logic FTYPE_SET  = 1'b0;
    localparam logic FTYPE_INFO = 1'b1;

    // Reply codes
    localparam logic [1:0] RESP_UA  = 2'd0;
    localparam logic [1:0] RESP_RR  = 2'd1;
    localparam logic [1:0] RESP_REJ = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT       = 3'd0,
        PH_AFTER_FLAG = 3'd1,
        PH_GOT_ADDR   = 3'd2,
        PH_GOT_CTRL   = 3'd3,
        PH_DATA       = 3'd4,
        PH_SET_END    = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic       is_info;
        logic       seq;
        logic       esc;
        logic       held_valid;
        logic [7:0] held_byte;
        logic [7:0] run_xor;
        logic       exp_seq;
    } rx_state_t;

    localparam rx_state_t RX_STATE_RESET = '{
        phase:      PH_HUNT,
        is_info:    1'b0,
        seq:        1'b0,
        esc:        1'b0,
        held_valid: 1'b0,
        held_byte:  8'h00,
        run_xor:    8'h00,
        exp_seq:    1'b0
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic       frame_type;
        logic       send_seq;
        logic       check_ok;
        logic [1:0] response;
        logic       response_seq;
        logic       last;
    } result_t;

    // Up to two results produced by one line byte, packed from slot 0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } result_pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfr_decode.sv =====
// Per-byte frame decoder: next receiver state and the results one line byte causes.
// Depends on lfr_pkg.
`default_nettype none

module lfr_decode
    import lfr_pkg::*;
(
    input  wire rx_state_t    cur,
    input  wire logic [7:0]   rx_byte,
    input  wire logic [7:0]   own_address,
    output rx_state_t         nxt,
    output result_pair_t      results
);

    logic       is_flag;
    logic       ctrl_ok;
    logic [7:0] ctrl_byte;
    logic       hdr_ok;
    logic [7:0] xor_mid;
    phase_t     phase_next;

    logic       a_v;
    logic       b_v;
    logic       v_v;
    logic       set_v;
    logic       ok;
    logic [1:0] resp;
    result_t    item_a;
    result_t    item_b;
    result_t    verdict;

    function automatic result_t data_item(input logic [7:0] d);
        result_t r;
        r              = '0;
        r.kind         = KIND_DATA;
        r.payload_byte = d;
        return r;
    endfunction

    assign is_flag   = (rx_byte == FLAG_BYTE);
    assign ctrl_ok   = (rx_byte == CTRL_SET) || (rx_byte == CTRL_I0) || (rx_byte == CTRL_I1);
    assign ctrl_byte = !cur.is_info ? CTRL_SET : (cur.seq ? CTRL_I1 : CTRL_I0);
    assign hdr_ok    = (rx_byte == (own_address ^ ctrl_byte));
    // Running check with the held byte folded in
    assign xor_mid   = cur.held_valid ? (cur.run_xor ^ cur.held_byte) : cur.run_xor;

    // Next header phase
    always_comb
    begin
        phase_next = cur.phase;
        case (cur.phase)
            PH_AFTER_FLAG:
            begin
                if (rx_byte == own_address)
                    phase_next = PH_GOT_ADDR;
                else if (!is_flag)
                    phase_next = PH_HUNT;
            end
            PH_GOT_ADDR:
            begin
                if (ctrl_ok)
                    phase_next = PH_GOT_CTRL;
                else
                    phase_next = is_flag ? PH_AFTER_FLAG : PH_HUNT;
            end
            PH_GOT_CTRL:
            begin
                if (hdr_ok)
                    phase_next = cur.is_info ? PH_DATA : PH_SET_END;
                else
                    phase_next = is_flag ? PH_AFTER_FLAG : PH_HUNT;
            end
            PH_SET_END:
            begin
                phase_next = is_flag ? PH_AFTER_FLAG : PH_HUNT;
            end
            PH_DATA:
            begin
                if (is_flag)
                    phase_next = PH_AFTER_FLAG;
            end
            default:
            begin
                phase_next = is_flag ? PH_AFTER_FLAG : PH_HUNT;
            end
        endcase
    end

    // Frame fields, destuffing, hold stage and check
    always_comb
    begin
        nxt.phase      = phase_next;
        nxt.is_info    = cur.is_info;
        nxt.seq        = cur.seq;
        nxt.esc        = cur.esc;
        nxt.held_valid = cur.held_valid;
        nxt.held_byte  = cur.held_byte;
        nxt.run_xor    = cur.run_xor;
        nxt.exp_seq    = cur.exp_seq;
        a_v            = 1'b0;
        b_v            = 1'b0;
        v_v            = 1'b0;
        set_v          = 1'b0;
        ok             = 1'b0;
        case (cur.phase)
            PH_GOT_ADDR:
            begin
                if (ctrl_ok)
                begin
                    nxt.is_info = (rx_byte != CTRL_SET);
                    nxt.seq     = (rx_byte == CTRL_I1);
                end
            end
            PH_GOT_CTRL:
            begin
                if (hdr_ok)
                begin
                    nxt.esc        = 1'b0;
                    nxt.held_valid = 1'b0;
                    nxt.held_byte  = 8'h00;
                    nxt.run_xor    = 8'h00;
                end
            end
            PH_SET_END:
            begin
                set_v = is_flag;
            end
            PH_DATA:
            begin
                if (is_flag)
                begin
                    // A dangling escape counts as a literal data byte
                    if (cur.esc)
                    begin
                        a_v = cur.held_valid;
                        ok  = (xor_mid == ESC_BYTE);
                    end
                    else
                    begin
                        ok = cur.held_valid && (cur.held_byte == cur.run_xor);
                    end
                    v_v = 1'b1;
                    if (ok && (cur.seq == cur.exp_seq))
                        nxt.exp_seq = ~cur.exp_seq;
                    nxt.esc        = 1'b0;
                    nxt.held_valid = 1'b0;
                    nxt.held_byte  = 8'h00;
                    nxt.run_xor    = 8'h00;
                end
                else if (cur.esc)
                begin
                    nxt.esc        = 1'b0;
                    a_v            = cur.held_valid;
                    nxt.held_valid = 1'b1;
                    if ((rx_byte == ESC_FLAG) || (rx_byte == ESC_ESC))
                    begin
                        nxt.held_byte = rx_byte ^ ESC_MASK;
                        nxt.run_xor   = xor_mid;
                    end
                    else
                    begin
                        // Bad escape: pass the escape and this byte literally
                        b_v           = 1'b1;
                        nxt.held_byte = rx_byte;
                        nxt.run_xor   = xor_mid ^ ESC_BYTE;
                    end
                end
                else if (rx_byte == ESC_BYTE)
                begin
                    nxt.esc = 1'b1;
                end
                else
                begin
                    a_v            = cur.held_valid;
                    nxt.held_valid = 1'b1;
                    nxt.held_byte  = rx_byte;
                    nxt.run_xor    = xor_mid;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Verdict for the closing flag
    always_comb
    begin
        if (ok)
            resp = RESP_RR;
        else if (cur.seq == cur.exp_seq)
            resp = RESP_REJ;
        else
            resp = RESP_RR;

        verdict              = '0;
        verdict.kind         = KIND_VERDICT;
        verdict.frame_type   = set_v ? FTYPE_SET : FTYPE_INFO;
        verdict.send_seq     = set_v ? 1'b0 : cur.seq;
        verdict.check_ok     = set_v ? 1'b1 : ok;
        verdict.response     = set_v ? RESP_UA : resp;
        verdict.response_seq = set_v ? 1'b0 : nxt.exp_seq;
    end

    assign item_a = data_item(cur.held_byte);
    assign item_b = data_item(ESC_BYTE);

    // Pack results into slots in emission order and mark the last one
    always_comb
    begin
        results    = '0;
        results.v0 = a_v || b_v || v_v || set_v;
        results.v1 = a_v && (b_v || v_v);
        if (a_v)
            results.r0 = item_a;
        else if (b_v)
            results.r0 = item_b;
        else
            results.r0 = verdict;
        results.r1         = b_v ? item_b : verdict;
        results.r0.last    = !results.v1;
        results.r1.last    = 1'b1;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfr_out_queue.sv =====
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on lfr_pkg.
`default_nettype none

module lfr_out_queue
    import lfr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_en,
    input  wire result_pair_t push,
    output logic              room,
    output logic              out_valid,
    input  wire logic         out_stall,
    output result_t           out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         slot_reg [DEPTH];
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   head_next;
    logic [PW-1:0]   tail_reg;
    logic [PW-1:0]   tail_next;
    logic [PW-1:0]   tail_plus1;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            pop;
    logic            wr0;
    logic            wr1;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop        = out_valid && !out_stall;
    assign wr0        = push_en && push.v0;
    assign wr1        = push_en && push.v1;
    assign tail_plus1 = ptr_inc(tail_reg);

    assign room      = (count_reg <= CW'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[head_reg];

    // Advance pointers and fill count
    always_comb
    begin
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = wr1 ? ptr_inc(tail_plus1) : (wr0 ? tail_plus1 : tail_reg);
        count_next = count_reg + CW'(wr0) + CW'(wr1) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store results in emission order
    always_ff @(posedge clk)
    begin
        if (wr0)
            slot_reg[tail_reg] <= push.r0;
        if (wr1)
            slot_reg[tail_plus1] <= push.r1;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/link_frame_receiver.sv =====
// Top level of the link frame receiver: state and address registers, decoder, result queue.
// Depends on lfr_pkg, lfr_decode and lfr_out_queue.
//
// Receives one line byte per transaction and can take a byte every clock cycle
// while the queue has room. Each byte is decoded in the cycle it is accepted and
// yields zero, one or two results (destuffed payload bytes, delayed by one byte,
// and an end-of-frame verdict with the UA, RR or REJ reply), which enter a
// QUEUE_DEPTH-entry result queue in order; results leave one per output
// transaction. The input is stalled while the queue has fewer than two free
// entries; a byte that yields two results (a bad escape, or an escape right
// before the closing flag) takes an output transaction for each. own_address
// resets to 1 and is written through the cfg channel, which is always ready.
`default_nettype none

module link_frame_receiver
    import lfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    // Line byte input
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    // Result output
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            kind,
    output logic [7:0]      payload_byte,
    output logic            frame_type,
    output logic            send_seq,
    output logic            check_ok,
    output logic [1:0]      response,
    output logic            response_seq,
    output logic            last
);

    rx_state_t    state_reg;
    rx_state_t    state_next;
    logic [7:0]   own_address_reg;
    result_pair_t results;
    result_t      out_item;
    logic         room;
    logic         in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign in_accept = in_valid && !in_stall;

    // Hold own address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_address_reg <= OWN_ADDR_RESET;
        else if (cfg_valid && cfg_ready)
            own_address_reg <= cfg_data;
    end

    // Advance receiver state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= RX_STATE_RESET;
        else if (in_accept)
            state_reg <= state_next;
    end

    lfr_decode u_decode (
        .cur         (state_reg),
        .rx_byte     (rx_byte),
        .own_address (own_address_reg),
        .nxt         (state_next),
        .results     (results)
    );

    lfr_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (in_accept),
        .push      (results),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    assign kind         = out_item.kind;
    assign payload_byte = out_item.payload_byte;
    assign frame_type   = out_item.frame_type;
    assign send_seq     = out_item.send_seq;
    assign check_ok     = out_item.check_ok;
    assign response     = out_item.response;
    assign response_seq = out_item.response_seq;
    assign last         = out_item.last;

`ifndef NO_ASSERTIONS
    // A held data byte exists only inside an information frame body
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.held_valid |-> (state_reg.phase == PH_DATA))
        else $error("held byte outside frame body");

    // A pending escape exists only inside an information frame body
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.esc |-> (state_reg.phase == PH_DATA))
        else $error("escape pending outside frame body");

    // The expected sequence bit moves only on an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(state_reg.exp_seq))
        else $error("expected sequence changed without a byte");
`endif

endmodule

`default_nettype wire

// ===== verif/link_frame_receiver_test.sv =====
// Self-checking testbench for link_frame_receiver: directed frames, then random frames.
// Depends on lfr_pkg and the link_frame_receiver RTL; needs no other files.
`timescale 1ns / 1ps

module link_frame_receiver_test;
    import lfr_pkg::*;

    localparam int PHASE_COUNT    = 5;
    localparam int PHASE_BYTES    = 64;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;

    // Directed stimulus: one line byte per row, verdict typed in where obvious
    typedef struct packed {
        logic [7:0] line_byte;
        logic       typed;
        result_t    want;
    } line_row_t;

    function automatic result_t verdict(logic ft, logic ss, logic ok, logic [1:0] rsp,
                                        logic rs);
        result_t r;
        r              = '0;
        r.kind         = KIND_VERDICT;
        r.frame_type   = ft;
        r.send_seq     = ss;
        r.check_ok     = ok;
        r.response     = rsp;
        r.response_seq = rs;
        r.last         = 1'b1;
        return r;
    endfunction

    localparam result_t NO_VERDICT = '0;
    localparam logic [7:0] ADDR = OWN_ADDR_RESET;
    localparam int DIRECTED_COUNT = 34;
    localparam line_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // SET frame answered by UA; closing flag opens the next frame
        '{FLAG_BYTE, 1'b0, NO_VERDICT},
        '{ADDR, 1'b0, NO_VERDICT},
        '{CTRL_SET, 1'b0, NO_VERDICT},
        '{ADDR ^ CTRL_SET, 1'b0, NO_VERDICT},
        '{FLAG_BYTE, 1'b1, verdict(FTYPE_SET, 1'b0, 1'b1, RESP_UA, 1'b0)},
        // good I-frame, seq 0: extremes, a proper escape and a bad escape
        '{ADDR, 1'b0, NO_VERDICT},
        '{CTRL_I0, 1'b0, NO_VERDICT},
        '{ADDR ^ CTRL_I0, 1'b0, NO_VERDICT},
        '{8'h00, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b0, NO_VERDICT},
        '{ESC_BYTE, 1'b0, NO_VERDICT},
        '{ESC_ESC, 1'b0, NO_VERDICT},
        '{ESC_BYTE, 1'b0, NO_VERDICT},
        '{8'h41, 1'b0, NO_VERDICT},
        '{8'hBE, 1'b0, NO_VERDICT},
        '{FLAG_BYTE, 1'b1, verdict(FTYPE_INFO, 1'b0, 1'b1, RESP_RR, 1'b1)},
        // new I-frame, seq 1, escape right before the flag: bad check gives REJ
        '{ADDR, 1'b0, NO_VERDICT},
        '{CTRL_I1, 1'b0, NO_VERDICT},
        '{ADDR ^ CTRL_I1, 1'b0, NO_VERDICT},
        '{ESC_BYTE, 1'b0, NO_VERDICT},
        '{FLAG_BYTE, 1'b1, verdict(FTYPE_INFO, 1'b1, 1'b0, RESP_REJ, 1'b1)},
        // empty duplicate I-frame, seq 0: check fails, still RR
        '{ADDR, 1'b0, NO_VERDICT},
        '{CTRL_I0, 1'b0, NO_VERDICT},
        '{ADDR ^ CTRL_I0, 1'b0, NO_VERDICT},
        '{FLAG_BYTE, 1'b1, verdict(FTYPE_INFO, 1'b0, 1'b0, RESP_RR, 1'b1)},
        // flag in place of control, then in place of header check
        '{ADDR, 1'b0, NO_VERDICT},
        '{FLAG_BYTE, 1'b0, NO_VERDICT},
        '{ADDR, 1'b0, NO_VERDICT},
        '{CTRL_SET, 1'b0, NO_VERDICT},
        '{FLAG_BYTE, 1'b0, NO_VERDICT},
        // SET header followed by a non-flag byte: no verdict
        '{ADDR, 1'b0, NO_VERDICT},
        '{CTRL_SET, 1'b0, NO_VERDICT},
        '{ADDR ^ CTRL_SET, 1'b0, NO_VERDICT},
        '{ESC_FLAG, 1'b0, NO_VERDICT}
    };

    localparam logic [7:0] PHASE_ADDRS [PHASE_COUNT] =
        '{8'h00, 8'hFF, FLAG_BYTE, 8'h00, OWN_ADDR_RESET};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [7:0] payload_byte;
    logic       frame_type;
    logic       send_seq;
    logic       check_ok;
    logic [1:0] response;
    logic       response_seq;
    logic       last;

    link_frame_receiver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .frame_type   (frame_type),
        .send_seq     (send_seq),
        .check_ok     (check_ok),
        .response     (response),
        .response_seq (response_seq),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver model state
    phase_t     hdr_phase;
    logic       cur_info;
    logic       cur_seq;
    logic       esc_seen;
    logic       hold_full;
    logic [7:0] hold_byte;
    logic [7:0] data_xor;
    logic       next_seq;
    logic [7:0] station_addr;

    result_t    step_results [$];
    result_t    awaited_results [$];
    logic [7:0] frame_bytes [$];

    int  mismatch_count = 0;
    int  results_checked = 0;
    int  bytes_sent = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  long_hold_req = 1'b0;
    bit  calm_mode = 1'b0;
    bit  sender_gapless = 1'b0;

    function automatic void reset_receiver_model();
        station_addr = OWN_ADDR_RESET;
        hdr_phase    = PH_HUNT;
        cur_info     = 1'b0;
        cur_seq      = 1'b0;
        esc_seen     = 1'b0;
        hold_full    = 1'b0;
        hold_byte    = 8'h00;
        data_xor     = 8'h00;
        next_seq     = 1'b0;
    endfunction

    function automatic void add_result(logic k, logic [7:0] d, logic ft, logic ss, logic ok,
                                       logic [1:0] rsp, logic rs);
        result_t r;
        r.kind         = k;
        r.payload_byte = d;
        r.frame_type   = ft;
        r.send_seq     = ss;
        r.check_ok     = ok;
        r.response     = rsp;
        r.response_seq = rs;
        r.last         = 1'b0;
        step_results.push_back(r);
    endfunction

    // Hold each destuffed byte back by one; release the previous one
    function automatic void shift_in_data(logic [7:0] d);
        if (hold_full)
        begin
            add_result(KIND_DATA, hold_byte, 1'b0, 1'b0, 1'b0, RESP_UA, 1'b0);
            data_xor = data_xor ^ hold_byte;
        end
        hold_byte = d;
        hold_full = 1'b1;
    endfunction

    function automatic logic [7:0] ctrl_code();
        if (!cur_info)
            return CTRL_SET;
        return cur_seq ? CTRL_I1 : CTRL_I0;
    endfunction

    function automatic void clear_data_path();
        esc_seen  = 1'b0;
        hold_full = 1'b0;
        hold_byte = 8'h00;
        data_xor  = 8'h00;
    endfunction

    // Give the verdict of an information frame; a good in-sequence frame advances the expected sequence
    function automatic void close_info_frame();
        logic       ok;
        logic [1:0] rsp;
        ok = hold_full && (hold_byte == data_xor);
        if (ok)
        begin
            if (cur_seq == next_seq)
                next_seq = ~next_seq;
            rsp = RESP_RR;
        end
        else
            rsp = (cur_seq == next_seq) ? RESP_REJ : RESP_RR;
        add_result(KIND_VERDICT, 8'h00, FTYPE_INFO, cur_seq, ok, rsp, next_seq);
        hdr_phase = PH_AFTER_FLAG;
        clear_data_path();
    endfunction

    // Advance the receiver model by one line byte; results land in step_results
    function automatic void decode_line_byte(logic [7:0] b);
        step_results.delete();
        case (hdr_phase)
            PH_AFTER_FLAG:
            begin
                if (b == station_addr)
                    hdr_phase = PH_GOT_ADDR;
                else if (b != FLAG_BYTE)
                    hdr_phase = PH_HUNT;
            end
            PH_GOT_ADDR:
            begin
                if (b == CTRL_SET || b == CTRL_I0 || b == CTRL_I1)
                begin
                    cur_info  = (b != CTRL_SET);
                    cur_seq   = (b == CTRL_I1);
                    hdr_phase = PH_GOT_CTRL;
                end
                else
                    hdr_phase = (b == FLAG_BYTE) ? PH_AFTER_FLAG : PH_HUNT;
            end
            PH_GOT_CTRL:
            begin
                if (b == (station_addr ^ ctrl_code()))
                begin
                    hdr_phase = cur_info ? PH_DATA : PH_SET_END;
                    clear_data_path();
                end
                else
                    hdr_phase = (b == FLAG_BYTE) ? PH_AFTER_FLAG : PH_HUNT;
            end
            PH_SET_END:
            begin
                if (b == FLAG_BYTE)
                begin
                    add_result(KIND_VERDICT, 8'h00, FTYPE_SET, 1'b0, 1'b1, RESP_UA, 1'b0);
                    hdr_phase = PH_AFTER_FLAG;
                end
                else
                    hdr_phase = PH_HUNT;
            end
            PH_DATA:
            begin
                if (b == FLAG_BYTE)
                begin
                    if (esc_seen)
                        shift_in_data(ESC_BYTE);
                    close_info_frame();
                end
                else if (esc_seen)
                begin
                    esc_seen = 1'b0;
                    if (b == ESC_FLAG || b == ESC_ESC)
                        shift_in_data(b ^ ESC_MASK);
                    else
                    begin
                        shift_in_data(ESC_BYTE);
                        shift_in_data(b);
                    end
                end
                else if (b == ESC_BYTE)
                    esc_seen = 1'b1;
                else
                    shift_in_data(b);
            end
            default:
                hdr_phase = (b == FLAG_BYTE) ? PH_AFTER_FLAG : PH_HUNT;
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_checked, name, got, want));
    endtask

    // Compare one output transaction with the oldest expectation
    task automatic check_result();
        result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      results_checked));
        end
        else
        begin
            want = awaited_results.pop_front();
            check_field("kind", 8'(kind), 8'(want.kind));
            check_field("payload_byte", payload_byte, want.payload_byte);
            check_field("frame_type", 8'(frame_type), 8'(want.frame_type));
            check_field("send_seq", 8'(send_seq), 8'(want.send_seq));
            check_field("check_ok", 8'(check_ok), 8'(want.check_ok));
            check_field("response", 8'(response), 8'(want.response));
            check_field("response_seq", 8'(response_seq), 8'(want.response_seq));
            check_field("last", 8'(last), 8'(want.last));
        end
        results_checked++;
    endtask

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int unsigned r;
        if (calm_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Check output transactions and drive the receiver's stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (hold_left > 0)
                hold_left--;
            else if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 3) == 0)
                stall_left = idle_len();
            out_stall <= (hold_left > 0) || (stall_left > 0);
        end
    end

    // End the run when no transaction happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offer one line byte, wait for its transaction, then record what it should cause
    task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
        int gap;
        gap = sender_gapless ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        decode_line_byte(b);
        if (typed)
            awaited_results.push_back(want);
        else
            foreach (step_results[i])
                awaited_results.push_back(step_results[i]);
        bytes_sent++;
    endtask

    // Drop the line and hold until every expected result has left the block
    task automatic wait_all_delivered();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic write_own_address(input logic [7:0] addr);
        wait_all_delivered();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        station_addr = addr;
    endtask

    // Data byte with a bias toward the line codes and the extremes
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            2:       return $urandom_range(0, 1) ? ESC_FLAG : ESC_ESC;
            3:       return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_stuffed(logic [7:0] d);
        if (d == FLAG_BYTE)
        begin
            frame_bytes.push_back(ESC_BYTE);
            frame_bytes.push_back(ESC_FLAG);
        end
        else if (d == ESC_BYTE)
        begin
            frame_bytes.push_back(ESC_BYTE);
            frame_bytes.push_back(ESC_ESC);
        end
        else
            frame_bytes.push_back(d);
    endfunction

    // Build and send one random frame; a length of zero or more forces a clean I-frame
    task automatic send_random_frame(input int force_len);
        int unsigned pick;
        int unsigned fault;
        int          len;
        logic        seq;
        logic [7:0]  ctrl;
        logic [7:0]  hdr;
        logic [7:0]  sum;
        logic [7:0]  d;
        logic [7:0]  odd;
        frame_bytes.delete();
        pick  = (force_len >= 0) ? 99 : $urandom_range(0, 99);
        fault = (force_len >= 0) ? 99 : $urandom_range(0, 99);
        if (pick < 10)
        begin
            // line noise
            repeat ($urandom_range(1, 4))
                frame_bytes.push_back(pick_data());
        end
        else
        begin
            if (pick < 20)
                ctrl = CTRL_SET;
            else
            begin
                seq  = 1'($urandom_range(0, 1));
                ctrl = seq ? CTRL_I1 : CTRL_I0;
            end
            hdr = station_addr ^ ctrl;
            if ($urandom_range(0, 9) < 7 || force_len >= 0)
                frame_bytes.push_back(FLAG_BYTE);
            // header, with an occasional fault
            frame_bytes.push_back(fault < 5 ? station_addr ^ 8'($urandom_range(1, 255))
                                            : station_addr);
            if (fault >= 5 && fault < 10)
            begin
                d = 8'($urandom_range(0, 255));
                if (d == CTRL_SET || d == CTRL_I0 || d == CTRL_I1)
                    d = d ^ 8'h10;
                frame_bytes.push_back(d);
            end
            else
                frame_bytes.push_back(ctrl);
            frame_bytes.push_back((fault >= 10 && fault < 15) ? hdr ^ 8'($urandom_range(1, 255))
                                                              : hdr);
            if (ctrl == CTRL_SET)
            begin
                frame_bytes.push_back($urandom_range(0, 9) < 8 ? FLAG_BYTE : pick_data());
            end
            else
            begin
                if (force_len >= 0)
                    len = force_len;
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(20, 48);
                else
                    len = $urandom_range(0, 6);
                sum = 8'h00;
                for (int i = 0; i < len; i++)
                begin
                    d   = pick_data();
                    sum = sum ^ d;
                    if (force_len < 0 && $urandom_range(0, 11) == 0)
                    begin
                        // bad escape: the pair passes through literally
                        odd = 8'($urandom_range(0, 255));
                        if (odd == ESC_FLAG || odd == ESC_ESC || odd == FLAG_BYTE)
                            odd = ESC_BYTE;
                        frame_bytes.push_back(ESC_BYTE);
                        frame_bytes.push_back(odd);
                    end
                    push_stuffed(d);
                end
                // data check, left out now and then on an empty frame
                if (len > 0 || $urandom_range(0, 1) == 1)
                    push_stuffed((fault >= 15 && fault < 27) ? sum ^ 8'($urandom_range(1, 255))
                                                             : sum);
                if (force_len < 0 && $urandom_range(0, 19) == 0)
                    frame_bytes.push_back(ESC_BYTE);
                frame_bytes.push_back(FLAG_BYTE);
            end
        end
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], 1'b0, NO_VERDICT);
    endtask

    initial
    begin
        int         phase_start;
        bit         paused;
        logic [7:0] addr;
        reset_receiver_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset address
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_byte(DIRECTED_ROWS[i].line_byte, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // random part, one address setting per phase
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            addr = (p == 3) ? 8'($urandom_range(0, 255)) : PHASE_ADDRS[p];
            write_own_address(addr);
            calm_mode = (p == 4);
            if (p == 1)
            begin
                // stall the output side while a long frame keeps coming
                long_hold_req  = 1'b1;
                sender_gapless = 1'b1;
                send_random_frame(40);
                sender_gapless = 1'b0;
            end
            phase_start = bytes_sent;
            paused      = 1'b0;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if (p == 2 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2)
                begin
                    wait_all_delivered();
                    paused = 1'b1;
                end
                send_random_frame(-1);
            end
        end

        wait_all_delivered();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      awaited_results.size()));
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
